FILE: rtl/tkpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpk_pkg
// Shared types and constants of the top-k probability keeper.
// ----------------------------------------------------------------------------
package tkpk_pkg;

  localparam int LABEL_W   = 10;
  localparam int PROB_W    = 16;
  localparam int KEEP_W    = 5;
  localparam int HCOUNT_W  = 5;
  localparam int HSUM_W    = 20;

  localparam logic [KEEP_W-1:0] KEEP_RESET  = 5'd16;
  localparam logic [HSUM_W-1:0] HSUM_MAX    = 20'hFFFFF;

  typedef enum logic [0:0] {
    REQ_OFFER = 1'b0,
    REQ_CLEAR = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic [LABEL_W-1:0] label_index;
    logic [PROB_W-1:0]  prob;
  } in_t;

  typedef struct packed {
    logic                accepted;
    logic                evicted_valid;
    logic [LABEL_W-1:0]  evicted_label;
    logic [HCOUNT_W-1:0] held_count;
    logic [HSUM_W-1:0]   held_sum;
  } out_t;

  // control of one scan word arriving from the slot store
  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage

FILE: rtl/tkpk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpk_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkpk_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tkpk_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpk_scan
// Running minimum over the slot words streamed out of the store, one compare
// per cycle. Strict less-than keeps the lowest slot among equal minima.
// ----------------------------------------------------------------------------
module tkpk_scan #(
  parameter int SLOT_W = 4,
  parameter int LBL_W  = 10
) (
  input  logic                     clk_i,
  input  tkpk_pkg::scan_ctl_t      ctl_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic [tkpk_pkg::PROB_W-1:0] prob_i,
  input  logic [LBL_W-1:0]         label_i,
  output logic [SLOT_W-1:0]        min_slot_o,
  output logic [tkpk_pkg::PROB_W-1:0] min_prob_o,
  output logic [LBL_W-1:0]         min_label_o
);

  import tkpk_pkg::*;

  logic [SLOT_W-1:0] min_slot_q, min_slot_d;
  logic [PROB_W-1:0] min_prob_q, min_prob_d;
  logic [LBL_W-1:0]  min_label_q, min_label_d;
  logic              take;

  always_comb begin
    take        = ctl_i.vld && (ctl_i.first || (prob_i < min_prob_q));
    min_slot_d  = min_slot_q;
    min_prob_d  = min_prob_q;
    min_label_d = min_label_q;
    if (take) begin
      min_slot_d  = slot_i;
      min_prob_d  = prob_i;
      min_label_d = label_i;
    end
  end

  always_ff @(posedge clk_i) begin
    min_slot_q  <= min_slot_d;
    min_prob_q  <= min_prob_d;
    min_label_q <= min_label_d;
  end

  assign min_slot_o  = min_slot_q;
  assign min_prob_o  = min_prob_q;
  assign min_label_o = min_label_q;

endmodule

FILE: rtl/top_k_probability_keeper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_probability_keeper
// Keeps the largest (label, probability) pairs offered so far and their sum.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o, in_data_i): one request word, either
//   an offer of a pair or a clear of the store. out channel (out_valid_o/
//   out_ready_i, out_data_o): one result word per request, in order.
//   cfg_we_i/cfg_wdata_i write keep_count; write it only while idle.
//   Flow: a clear, an offer into a free slot, or an offer against an
//   empty store goes from the check state straight to emit. A full store
//   scans the held slots through the one RAM read port and the one compare
//   unit, one slot a cycle, then drains and decides. The block takes one
//   request at a time. The result register is separate: the next request is
//   taken while a result still waits. If the receiver stalls, a finished
//   request holds in the emit state until the result register frees up.
//   Reset empties the store (count and sum to zero) and sets keep_count to
//   16; slot contents need no clearing since only filled slots are read.
// ----------------------------------------------------------------------------
module top_k_probability_keeper #(
  parameter int MAX_KEEP   = 16,
  parameter int LABEL_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tkpk_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tkpk_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tkpk_pkg::KEEP_W-1:0]   cfg_wdata_i
);

  import tkpk_pkg::*;

  localparam int SLOT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W  = $clog2(MAX_KEEP + 1);
  localparam int SUM_W  = PROB_W + $clog2(MAX_KEEP + 1);
  localparam int LBL_W  = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int WORD_W = LBL_W + PROB_W;

  state_e              state_q, state_d;
  in_t                 in_q;
  logic [KEEP_W-1:0]   keep_q, keep_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SLOT_W-1:0]   addr_q, addr_d;
  scan_ctl_t           rd_ctl_q, rd_ctl_d;
  logic                rd_last_q, rd_last_d;
  logic [SLOT_W-1:0]   rd_slot_q, rd_slot_d;
  logic                acc_q, acc_d;
  logic                ev_q, ev_d;
  logic [LABEL_W-1:0]  ev_label_q, ev_label_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                room;
  logic                scan_last;
  logic                load_out;
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]   min_slot;
  logic [PROB_W-1:0]   min_prob;
  logic [LBL_W-1:0]    min_label;
  logic [HSUM_W-1:0]   held_sum;

  // room in a free slot: below both the written limit and the store depth
  assign room = (8'(fill_q) < 8'(keep_q)) && (8'(fill_q) < 8'(MAX_KEEP));
  assign scan_last = (CNT_W'(addr_q) == (fill_q - CNT_W'(1)));
  assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign held_sum  = (sum_q > SUM_W'(HSUM_MAX)) ? HSUM_MAX : HSUM_W'(sum_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_q.req_type == REQ_CLEAR || room || fill_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    keep_d      = keep_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    addr_d      = addr_q;
    rd_ctl_d    = '0;
    rd_last_d   = 1'b0;
    rd_slot_d   = rd_slot_q;
    acc_d       = acc_q;
    ev_d        = ev_q;
    ev_label_d  = ev_label_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = SLOT_W'(fill_q);
    ram_wdata   = {in_q.label_index[LBL_W-1:0], in_q.prob};
    in_ready_o  = 1'b0;

    if (cfg_we_i) begin
      keep_d = cfg_wdata_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_CHECK: begin
        acc_d      = 1'b0;
        ev_d       = 1'b0;
        ev_label_d = '0;
        addr_d     = '0;
        if (in_q.req_type == REQ_CLEAR) begin
          fill_d = '0;
          sum_d  = '0;
        end else if (room) begin
          ram_we = 1'b1;
          fill_d = fill_q + CNT_W'(1);
          sum_d  = sum_q + SUM_W'(in_q.prob);
          acc_d  = 1'b1;
        end
      end
      ST_SCAN: begin
        // issue one slot read a cycle; the read data is registered and comes back in the next cycle
        ram_re         = 1'b1;
        rd_ctl_d.vld   = 1'b1;
        rd_ctl_d.first = (addr_q == '0);
        rd_last_d      = scan_last;
        rd_slot_d      = addr_q;
        addr_d         = addr_q + SLOT_W'(1);
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        if (in_q.prob > min_prob) begin
          ram_we     = 1'b1;
          ram_waddr  = min_slot;
          sum_d      = sum_q - SUM_W'(min_prob) + SUM_W'(in_q.prob);
          acc_d      = 1'b1;
          ev_d       = 1'b1;
          ev_label_d = LABEL_W'(min_label);
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d         = 1'b1;
          out_d.accepted      = acc_q;
          out_d.evicted_valid = ev_q;
          out_d.evicted_label = ev_label_q;
          out_d.held_count    = HCOUNT_W'(fill_q);
          out_d.held_sum      = held_sum;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KEEP_RESET;
      fill_q      <= '0;
      sum_q       <= '0;
      rd_ctl_q    <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      keep_q      <= keep_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      rd_ctl_q    <= rd_ctl_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    addr_q     <= addr_d;
    rd_slot_q  <= rd_slot_d;
    acc_q      <= acc_d;
    ev_q       <= ev_d;
    ev_label_q <= ev_label_d;
    out_q      <= out_d;
  end

  tkpk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_KEEP)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  tkpk_scan #(
    .SLOT_W (SLOT_W),
    .LBL_W  (LBL_W)
  ) u_scan (
    .clk_i       (clk_i),
    .ctl_i       (rd_ctl_q),
    .slot_i      (rd_slot_q),
    .prob_i      (ram_rdata[PROB_W-1:0]),
    .label_i     (ram_rdata[WORD_W-1:PROB_W]),
    .min_slot_o  (min_slot),
    .min_prob_o  (min_prob),
    .min_label_o (min_label)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_KEEP))
    else $error("held count above store depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && in_q.req_type == REQ_CLEAR) |=> (fill_q == '0 && sum_q == '0))
    else $error("clear did not empty the store");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ctl_q.vld && rd_last_q) |-> (state_q == ST_DRAIN))
    else $error("last scan word outside drain state");

  a_evict_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.evicted_valid) |-> out_data_o.accepted)
    else $error("eviction without acceptance");

endmodule

FILE: tb/sv/top_k_probability_keeper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_probability_keeper_tb
// Self-checking bench for the top-k probability keeper. A driver feeds
// request words from a queue and a monitor takes result words, both with
// random idle bursts. A cycle-accurate-free predictor tracks the held pairs,
// the count and the sum and checks every result word field by field.
// keep_count is rewritten between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module top_k_probability_keeper_tb;
  import tkpk_pkg::*;

  localparam int KEEP_DEPTH = 16;
  localparam int KEEP_IW    = $clog2(KEEP_DEPTH);
  localparam int LAB_BITS   = 10;
  localparam int CYCLE_LIMIT = 500000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [KEEP_W-1:0]   cfg_wdata_i = KEEP_RESET;

  top_k_probability_keeper #(
    .MAX_KEEP   (KEEP_DEPTH),
    .LABEL_BITS (LAB_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [LABEL_W-1:0]  held_label [KEEP_DEPTH];
  logic [PROB_W-1:0]   held_prob  [KEEP_DEPTH];
  logic [HCOUNT_W-1:0] held_n = '0;
  logic [HSUM_W:0]     prob_total = '0;
  logic [KEEP_W-1:0]   keep_limit = KEEP_RESET;

  in_t   request_q [$];
  out_t  due_result_q [$];
  out_t  due_word;
  int    issued_cnt = 0;
  int    checked_cnt = 0;
  int    err_cnt = 0;
  int    cycle_cnt = 0;
  int    gap_left = 0;
  int    stall_left = 0;
  bit    no_idle = 1'b0;

  function automatic out_t keeper_step(in_t w);
    out_t r;
    int   lim;
    int   low;
    r = '0;
    lim = (int'(keep_limit) > KEEP_DEPTH) ? KEEP_DEPTH : int'(keep_limit);
    if (w.req_type == REQ_CLEAR) begin
      held_n = '0;
      prob_total = '0;
    end else if (int'(held_n) < lim) begin
      held_label[held_n[KEEP_IW-1:0]] = w.label_index;
      held_prob[held_n[KEEP_IW-1:0]] = w.prob;
      held_n = held_n + HCOUNT_W'(1);
      prob_total = prob_total + (HSUM_W+1)'(w.prob);
      r.accepted = 1'b1;
    end else if (held_n != '0) begin
      // lowest slot wins among equal minima
      low = 0;
      for (int s = 1; s < int'(held_n); s++) begin
        if (held_prob[s[KEEP_IW-1:0]] < held_prob[low[KEEP_IW-1:0]]) low = s;
      end
      if (w.prob > held_prob[low[KEEP_IW-1:0]]) begin
        r.accepted = 1'b1;
        r.evicted_valid = 1'b1;
        r.evicted_label = held_label[low[KEEP_IW-1:0]];
        prob_total = prob_total - (HSUM_W+1)'(held_prob[low[KEEP_IW-1:0]])
                     + (HSUM_W+1)'(w.prob);
        held_label[low[KEEP_IW-1:0]] = w.label_index;
        held_prob[low[KEEP_IW-1:0]] = w.prob;
      end
    end
    r.held_count = held_n;
    r.held_sum = (prob_total > {1'b0, HSUM_MAX}) ? HSUM_MAX : prob_total[HSUM_W-1:0];
    return r;
  endfunction

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // driver: hold a word until taken, otherwise idle in bursts or send the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) due_result_q.push_back(keeper_step(in_data_i));
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= request_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor: check each taken result word, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_result_q.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, out_data_o);
          err_cnt++;
        end else begin
          due_word = due_result_q.pop_front();
          report_field("accepted", int'(due_word.accepted),
                       int'(out_data_o.accepted));
          report_field("evicted_valid", int'(due_word.evicted_valid),
                       int'(out_data_o.evicted_valid));
          report_field("evicted_label", int'(due_word.evicted_label),
                       int'(out_data_o.evicted_label));
          report_field("held_count", int'(due_word.held_count),
                       int'(out_data_o.held_count));
          report_field("held_sum", int'(due_word.held_sum),
                       int'(out_data_o.held_sum));
        end
        checked_cnt++;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("top_k_probability_keeper_tb: errors");
      $finish;
    end
  end

  task automatic offer(int lab, int p);
    in_t w;
    w.req_type = REQ_OFFER;
    w.label_index = LABEL_W'(lab);
    w.prob = PROB_W'(p);
    request_q.push_back(w);
    issued_cnt++;
  endtask

  task automatic clear_store();
    in_t w;
    w = '0;
    w.req_type = REQ_CLEAR;
    w.label_index = LABEL_W'($urandom_range(0, 1023));
    w.prob = PROB_W'($urandom_range(0, 65535));
    request_q.push_back(w);
    issued_cnt++;
  endtask

  // wait until every issued word has its result
  task automatic drain();
    while (checked_cnt != issued_cnt) @(posedge clk_i);
  endtask

  task automatic set_keep(int v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= KEEP_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keep_limit = KEEP_W'(v);
  endtask

  task automatic random_request();
    int p;
    if ($urandom_range(0, 39) == 0) begin
      clear_store();
    end else begin
      case ($urandom_range(0, 9))
        0:       p = 0;
        1:       p = 16'hFFFF;
        2, 3:    p = $urandom_range(0, 7);
        4:       p = $urandom_range(0, 7) << 13;
        default: p = $urandom_range(0, 65535);
      endcase
      offer($urandom_range(0, 1023), p);
    end
  endtask

  initial begin
    int keep_pick [6] = '{31, 1, 0, 16, 2, 17};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit: extremes, then clear
    offer(10'h3FF, 16'hFFFF);
    offer(0, 0);
    clear_store();

    // fill three, tie rejected, lowest equal minimum evicted
    set_keep(3);
    offer(1, 100);
    offer(2, 50);
    offer(3, 50);
    offer(4, 50);
    offer(5, 60);
    offer(6, 10);
    offer(10'h3FF, 16'hFFFF);

    // limit lowered below the held count
    set_keep(1);
    offer(7, 70);

    // zero limit: replacement rule with pairs held, nothing when empty
    set_keep(0);
    offer(8, 0);
    clear_store();
    offer(9, 16'hFFFF);

    for (int ph = 0; ph < 12; ph++) begin
      set_keep(ph < 6 ? keep_pick[ph] : $urandom_range(0, 31));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (100) random_request();
    end

    // last stretch runs at full rate
    set_keep(16);
    no_idle = 1'b1;
    repeat (100) random_request();

    drain();
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0 && due_result_q.size() == 0) begin
      $display("top_k_probability_keeper_tb: clean");
    end else begin
      $display("top_k_probability_keeper_tb: errors");
    end
    $finish;
  end

endmodule
